>>> sv/pbfd_pkg.sv
// Shared types and constants for the push-button fade dimmer.
package pbfd_pkg;

  localparam int unsigned DB_W    = 10;
  localparam int unsigned ANIM_W  = 10;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [DB_W-1:0]    DB_CNT_MAX   = '1;
  localparam logic [ANIM_W-1:0]  ANIM_CNT_MAX = '1;
  localparam logic [HOLD_W-1:0]  HOLD_CNT_MAX = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL   = '1;

  localparam logic [DB_W-1:0]    DEBOUNCE_RST   = 10'd50;
  localparam logic [ANIM_W-1:0]  ANIM_PER_RST   = 10'd10;
  localparam logic [HOLD_W-1:0]  LONG_PRESS_RST = 16'd2000;
  localparam logic [LEVEL_W-1:0] FADE_STEP_RST  = 8'd4;
  localparam logic [LEVEL_W-1:0] SETUP_STEP_RST = 8'd1;

  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_ANIM_PER   = 3'd1,
    REG_LONG_PRESS = 3'd2,
    REG_FADE_STEP  = 3'd3,
    REG_SETUP_STEP = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DB_W-1:0]    debounce_ms;
    logic [ANIM_W-1:0]  animation_period_ms;
    logic [HOLD_W-1:0]  long_press_ms;
    logic [LEVEL_W-1:0] fade_step;
    logic [LEVEL_W-1:0] setup_step;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_level;
    logic               lamp_on;
    logic               in_setup;
    logic               held;
  } res_t;

endpackage

>>> sv/pbfd_engine.sv
// Dimmer state and the per-tick debounce, hold and fade update.
module pbfd_engine
  import pbfd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic pressed,
  input  cfg_t cfg,
  output res_t res
);

  logic               held_state, held_state_next;
  logic               pending, pending_next;
  logic [DB_W-1:0]    debounce_count, debounce_count_next;
  logic [ANIM_W-1:0]  anim_count, anim_count_next;
  logic [HOLD_W-1:0]  hold_count, hold_count_next;
  logic [LEVEL_W-1:0] level, level_next;
  logic [LEVEL_W-1:0] target_level, target_level_next;
  logic [LEVEL_W-1:0] step_mag, step_mag_next;
  logic               step_down, step_down_next;
  logic               on_flag, on_flag_next;
  logic               setup_flag, setup_flag_next;
  logic [LEVEL_W-1:0] max_level, max_level_next;

  logic               sample;
  logic               just_pressed;
  logic               just_released;
  logic               overshoot;
  logic [LEVEL_W:0]   up_sum;
  logic [LEVEL_W:0]   down_limit;

  always_comb begin
    held_state_next     = held_state;
    pending_next        = pending;
    debounce_count_next = (debounce_count == DB_CNT_MAX) ? debounce_count
                                                         : debounce_count + 1'b1;
    anim_count_next     = (anim_count == ANIM_CNT_MAX) ? anim_count : anim_count + 1'b1;
    hold_count_next     = (hold_count == HOLD_CNT_MAX) ? hold_count : hold_count + 1'b1;
    level_next          = level;
    target_level_next   = target_level;
    step_mag_next       = step_mag;
    step_down_next      = step_down;
    on_flag_next        = on_flag;
    setup_flag_next     = setup_flag;
    max_level_next      = max_level;
    just_pressed        = 1'b0;
    just_released       = 1'b0;
    overshoot           = 1'b0;
    up_sum              = '0;
    down_limit          = '0;

    // The pin is ignored until the debounce window after an edge has run out.
    sample = !(pending && (debounce_count_next < cfg.debounce_ms));
    if (sample) begin
      if (pressed != held_state) begin
        just_pressed    = pressed;
        just_released   = !pressed;
        held_state_next = pressed;
        pending_next    = 1'b1;
      end else begin
        pending_next = 1'b0;
      end
      debounce_count_next = '0;
    end

    if (just_pressed) begin
      hold_count_next = '0;
      step_mag_next   = cfg.fade_step;
      if (on_flag) begin
        on_flag_next      = 1'b0;
        target_level_next = '0;
        step_down_next    = 1'b1;
      end else begin
        on_flag_next      = 1'b1;
        target_level_next = max_level;
        step_down_next    = 1'b0;
      end
    end

    if (just_released) begin
      hold_count_next = '0;
      if (setup_flag) begin
        setup_flag_next = 1'b0;
        max_level_next  = level;
        step_mag_next   = '0;
      end
    end

    if (held_state_next && !setup_flag_next && (hold_count_next > cfg.long_press_ms)) begin
      setup_flag_next = 1'b1;
      step_mag_next   = cfg.setup_step;
      if (level == '0) begin
        step_down_next    = 1'b0;
        target_level_next = LEVEL_FULL;
      end else begin
        step_down_next    = 1'b1;
        target_level_next = '0;
      end
    end

    if (anim_count_next >= cfg.animation_period_ms) begin
      anim_count_next = '0;
      if (step_mag_next != '0) begin
        up_sum     = {1'b0, level} + {1'b0, step_mag_next};
        down_limit = {1'b0, target_level_next} + {1'b0, step_mag_next};
        if (step_down_next) begin
          overshoot = ({1'b0, level} < down_limit);
          if (!overshoot) begin
            level_next = level - step_mag_next;
          end
        end else begin
          overshoot = (up_sum > {1'b0, target_level_next});
          if (!overshoot) begin
            level_next = up_sum[LEVEL_W-1:0];
          end
        end
        // A step that passes the target lands on it; the setup sweep turns around.
        if (overshoot) begin
          level_next = target_level_next;
          if (setup_flag_next) begin
            target_level_next = step_down_next ? LEVEL_FULL : '0;
            step_down_next    = !step_down_next;
          end else begin
            step_mag_next = '0;
          end
        end
      end
    end
  end

  always_comb begin
    res.pwm_level = level_next;
    res.lamp_on   = on_flag_next;
    res.in_setup  = setup_flag_next;
    res.held      = held_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_state     <= 1'b0;
      pending        <= 1'b0;
      debounce_count <= '0;
      anim_count     <= '0;
      hold_count     <= '0;
      level          <= '0;
      target_level   <= '0;
      step_mag       <= '0;
      step_down      <= 1'b0;
      on_flag        <= 1'b0;
      setup_flag     <= 1'b0;
      max_level      <= LEVEL_FULL;
    end else if (en) begin
      held_state     <= held_state_next;
      pending        <= pending_next;
      debounce_count <= debounce_count_next;
      anim_count     <= anim_count_next;
      hold_count     <= hold_count_next;
      level          <= level_next;
      target_level   <= target_level_next;
      step_mag       <= step_mag_next;
      step_down      <= step_down_next;
      on_flag        <= on_flag_next;
      setup_flag     <= setup_flag_next;
      max_level      <= max_level_next;
    end
  end

  // Setup mode can only be active while the debounced button is held.
  a_setup_needs_hold: assert property (@(posedge clk) disable iff (rst)
    setup_flag |-> held_state)
    else $error("setup mode active while button released");

  // Entering setup loads the sweep step.
  a_setup_step_loaded: assert property (@(posedge clk) disable iff (rst)
    $rose(setup_flag) |-> (step_mag == $past(cfg.setup_step)))
    else $error("setup entered without the sweep step");

  // Without a tick the level and the mode stay where they are.
  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(level) && $stable(setup_flag)))
    else $error("dimmer state moved without a tick");

endmodule

>>> sv/push_button_fade_dimmer_core.sv
// Top level of the push-button fade dimmer: request channels, registers, result stage.
//
// Each input request is one millisecond tick carrying the raw pull-up button
// level (0 means pressed); each tick yields exactly one result request with the
// PWM level, the lamp-on flag, the setup-mode flag and the debounced button
// state. A tick is captured in an input register; once the output register is
// free or being emptied, the dimmer state is updated and the result written
// into the output register. One tick can be accepted every clock cycle while
// the output is not stalled; the state update loop in pbfd_engine sets that
// rate. The input stalls only when its register holds a tick and the output
// register is full and stalled. The five timing and step registers sit on the
// APB port at byte addresses 0, 4, 8, 12 and 16 and should be written only
// while no tick is in flight. Unused addresses read as zero and ignore writes.
module push_button_fade_dimmer_core
  import pbfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Tick channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              button_level,
  // Result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LEVEL_W-1:0] pwm_level,
  output logic              lamp_on,
  output logic              in_setup,
  output logic              held,
  // Register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_write;

  // Input register holding one tick.
  logic     s1_valid;
  logic     s1_pressed;
  logic     s1_move;
  logic     in_take;

  res_t     res;

  // ---------------------------------------------------------------------------
  // Configuration registers. The word index is taken from paddr[4:2].
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms         <= DEBOUNCE_RST;
      cfg.animation_period_ms <= ANIM_PER_RST;
      cfg.long_press_ms       <= LONG_PRESS_RST;
      cfg.fade_step           <= FADE_STEP_RST;
      cfg.setup_step          <= SETUP_STEP_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_DEBOUNCE:   cfg.debounce_ms         <= pwdata[DB_W-1:0];
        REG_ANIM_PER:   cfg.animation_period_ms <= pwdata[ANIM_W-1:0];
        REG_LONG_PRESS: cfg.long_press_ms       <= pwdata[HOLD_W-1:0];
        REG_FADE_STEP:  cfg.fade_step           <= pwdata[LEVEL_W-1:0];
        REG_SETUP_STEP: cfg.setup_step          <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE:   prdata = DATA_W'(cfg.debounce_ms);
      REG_ANIM_PER:   prdata = DATA_W'(cfg.animation_period_ms);
      REG_LONG_PRESS: prdata = DATA_W'(cfg.long_press_ms);
      REG_FADE_STEP:  prdata = DATA_W'(cfg.fade_step);
      REG_SETUP_STEP: prdata = DATA_W'(cfg.setup_step);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. The held tick moves on whenever the output register is
  // free or is being emptied in the same cycle.
  // ---------------------------------------------------------------------------
  assign s1_move  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !s1_move);
    end
  end

  // The pin is active low.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pressed <= !button_level;
    end
  end

  pbfd_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .en      (s1_move),
    .pressed (s1_pressed),
    .cfg     (cfg),
    .res     (res)
  );

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pwm_level <= res.pwm_level;
      lamp_on   <= res.lamp_on;
      in_setup  <= res.in_setup;
      held      <= res.held;
    end
  end

  // A tick that leaves the input register always shows up as a result.
  a_tick_to_result: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("tick processed without a result");

  // The input only stalls while a tick is waiting in the input register.
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // A result in setup mode always reports the button held.
  a_setup_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_setup) |-> held)
    else $error("setup result with released button");

endmodule

>>> dv/push_button_fade_dimmer_core_tb.sv
// Self-checking testbench for the push-button fade dimmer core: directed plan, random gestures.
`timescale 1ns / 1ps

module push_button_fade_dimmer_core_tb;
  import pbfd_pkg::*;

  localparam int unsigned CLK_HALF       = 5;
  localparam int unsigned RST_CYCLES     = 5;
  localparam int unsigned NUM_SEGS       = 10;
  localparam int unsigned SEG_TICKS      = 35;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned NROWS          = 29;

  // Addresses past the last register; writes there must leave every setting alone.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_TICKS, ROW_WRITE} row_op_t;

  // One line of the directed plan: either a run of identical ticks or a register write.
  // A run may carry a hand-typed result for its last tick.
  typedef struct packed {
    row_op_t     op;
    logic        btn;
    logic [16:0] reps;
    logic [2:0]  idx;
    logic [31:0] val;
    logic        typed;
    res_t        want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               button_level = 1'b1;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LEVEL_W-1:0] pwm_level;
  logic               lamp_on;
  logic               in_setup;
  logic               held;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  push_button_fade_dimmer_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pwm_level    (pwm_level),
    .lamp_on      (lamp_on),
    .in_setup     (in_setup),
    .held         (held),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Settings as the testbench believes the block holds them. They only change while
  // no request is in flight, so the predictor may read them at any time.
  cfg_t shadow_cfg = '{DEBOUNCE_RST, ANIM_PER_RST, LONG_PRESS_RST, FADE_STEP_RST,
                       SETUP_STEP_RST};

  // Private copy of the dimmer state, advanced once per accepted tick request.
  logic                held_q;
  logic                db_pending;
  logic [DB_W-1:0]     db_cnt;
  logic [ANIM_W-1:0]   anim_cnt;
  logic [HOLD_W-1:0]   hold_cnt;
  logic [LEVEL_W-1:0]  lvl;
  logic [LEVEL_W-1:0]  target_lvl;
  logic [LEVEL_W-1:0]  max_lvl;
  logic signed [LEVEL_W:0] fade_dir;
  logic                on_q;
  logic                setup_q;

  res_t awaited_lamp_q[$];
  res_t pred_r;
  res_t want_r;
  int   err_cnt = 0;
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  // Sideband that travels with the tick being offered: a hand-typed result, if any.
  logic cur_typed = 1'b0;
  res_t cur_want = '0;

  stim_row_t plan [NROWS];

  // Works out the lamp outputs for one tick with the raw pin level btn.
  task automatic next_lamp_state(input logic btn, output res_t r);
    logic pressed_now;
    logic rise;
    logic fall;
    int   nxt;
    pressed_now = !btn;
    rise = 1'b0;
    fall = 1'b0;
    // All timers count first and stick at their top value.
    if (db_cnt != DB_CNT_MAX) db_cnt++;
    if (anim_cnt != ANIM_CNT_MAX) anim_cnt++;
    if (hold_cnt != HOLD_CNT_MAX) hold_cnt++;
    // The pin is looked at unless a debounce window is still open.
    if (!(db_pending && db_cnt < shadow_cfg.debounce_ms)) begin
      if (pressed_now != held_q) begin
        rise = pressed_now;
        fall = !pressed_now;
        held_q = pressed_now;
        db_pending = 1'b1;
      end else begin
        db_pending = 1'b0;
      end
      db_cnt = '0;
    end
    if (rise) begin
      hold_cnt = '0;
      if (on_q) begin
        on_q = 1'b0;
        target_lvl = '0;
        fade_dir = -$signed({1'b0, shadow_cfg.fade_step});
      end else begin
        on_q = 1'b1;
        target_lvl = max_lvl;
        fade_dir = $signed({1'b0, shadow_cfg.fade_step});
      end
    end
    if (fall) begin
      hold_cnt = '0;
      if (setup_q) begin
        setup_q = 1'b0;
        max_lvl = lvl;
        fade_dir = '0;
      end
    end
    if (held_q && !setup_q && hold_cnt > shadow_cfg.long_press_ms) begin
      setup_q = 1'b1;
      if (lvl == '0) begin
        fade_dir = $signed({1'b0, shadow_cfg.setup_step});
        target_lvl = LEVEL_FULL;
      end else begin
        fade_dir = -$signed({1'b0, shadow_cfg.setup_step});
        target_lvl = '0;
      end
    end
    if (anim_cnt >= shadow_cfg.animation_period_ms) begin
      anim_cnt = '0;
      nxt = int'(lvl) + int'(fade_dir);
      // A step that would pass the target lands on it; the setup sweep then turns around.
      if (fade_dir > 0) begin
        if (nxt > int'(target_lvl)) begin
          lvl = target_lvl;
          if (setup_q) begin
            fade_dir = -fade_dir;
            target_lvl = '0;
          end else begin
            fade_dir = '0;
          end
        end else begin
          lvl = nxt[LEVEL_W-1:0];
        end
      end else if (fade_dir < 0) begin
        if (nxt < int'(target_lvl)) begin
          lvl = target_lvl;
          if (setup_q) begin
            fade_dir = -fade_dir;
            target_lvl = LEVEL_FULL;
          end else begin
            fade_dir = '0;
          end
        end else begin
          lvl = nxt[LEVEL_W-1:0];
        end
      end
    end
    r = '{lvl, on_q, setup_q, held_q};
  endtask

  // Both channels are observed at the rising edge, before the block's registers move.
  // An accepted tick request is run through the predictor at once; an accepted result
  // request is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      held_q     = 1'b0;
      db_pending = 1'b0;
      db_cnt     = '0;
      anim_cnt   = '0;
      hold_cnt   = '0;
      lvl        = '0;
      target_lvl = '0;
      max_lvl    = LEVEL_FULL;
      fade_dir   = '0;
      on_q       = 1'b0;
      setup_q    = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_lamp_state(button_level, pred_r);
        awaited_lamp_q.push_back(cur_typed ? cur_want : pred_r);
      end
      if (out_valid && !out_stall) begin
        if (awaited_lamp_q.size() == 0) begin
          $error("result request arrived with no tick awaiting one");
          err_cnt++;
        end else begin
          want_r = awaited_lamp_q.pop_front();
          if (want_r.pwm_level !== pwm_level) begin
            $error("pwm_level expected %0d got %0d", want_r.pwm_level, pwm_level);
            err_cnt++;
          end
          if (want_r.lamp_on !== lamp_on) begin
            $error("lamp_on expected %0d got %0d", want_r.lamp_on, lamp_on);
            err_cnt++;
          end
          if (want_r.in_setup !== in_setup) begin
            $error("in_setup expected %0d got %0d", want_r.in_setup, in_setup);
            err_cnt++;
          end
          if (want_r.held !== held) begin
            $error("held expected %0d got %0d", want_r.held, held);
            err_cnt++;
          end
        end
      end
    end
  end

  // The watchdog only counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The result side stalls at random with the current phase's rate.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  function automatic stim_row_t tick_row(input logic btn, input int unsigned reps,
                                         input logic typed = 1'b0, input res_t want = '0);
    tick_row = '{ROW_TICKS, btn, reps[16:0], 3'd0, 32'd0, typed, want};
  endfunction

  function automatic stim_row_t write_row(input logic [2:0] idx, input logic [31:0] val);
    write_row = '{ROW_WRITE, 1'b1, 17'd0, idx, val, 1'b0, res_t'('0)};
  endfunction

  // Picks a register value: mostly small so that gestures stay short, with the ends
  // of the range and fully random values mixed in.
  function automatic logic [15:0] pick_field(input int unsigned full, input int unsigned low_hi);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) pick_field = '0;
    else if (r == 1) pick_field = full[15:0];
    else if (r == 2) pick_field = 16'($urandom_range(full));
    else pick_field = 16'($urandom_range(low_hi));
  endfunction

  // All driving tasks start and end just after a falling edge.
  task automatic send_tick(input logic btn, input logic typed, input res_t want);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    button_level <= btn;
    cur_typed    <= typed;
    cur_want     <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_run(input logic btn, input int unsigned n, input logic typed = 1'b0,
                          input res_t want = '0);
    for (int unsigned i = 0; i < n; i++) begin
      send_tick(btn, typed && (i == n - 1), want);
    end
  endtask

  // Waits until every tick has produced its result, plus a margin for the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_lamp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_read(input logic [2:0] idx, output logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Writes one register, mirrors it into the shadow copy and, for a known register, reads it back.
  task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] stored;
    logic [DATA_W-1:0] readback;
    logic              known;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    known = 1'b1;
    case (idx)
      REG_DEBOUNCE:   shadow_cfg.debounce_ms         = data[DB_W-1:0];
      REG_ANIM_PER:   shadow_cfg.animation_period_ms = data[ANIM_W-1:0];
      REG_LONG_PRESS: shadow_cfg.long_press_ms       = data[HOLD_W-1:0];
      REG_FADE_STEP:  shadow_cfg.fade_step           = data[LEVEL_W-1:0];
      REG_SETUP_STEP: shadow_cfg.setup_step          = data[LEVEL_W-1:0];
      default:        known = 1'b0;
    endcase
    case (idx)
      REG_DEBOUNCE:   stored = DATA_W'(shadow_cfg.debounce_ms);
      REG_ANIM_PER:   stored = DATA_W'(shadow_cfg.animation_period_ms);
      REG_LONG_PRESS: stored = DATA_W'(shadow_cfg.long_press_ms);
      REG_FADE_STEP:  stored = DATA_W'(shadow_cfg.fade_step);
      default:        stored = DATA_W'(shadow_cfg.setup_step);
    endcase
    if (known) begin
      reg_read(idx, readback);
      if (readback !== stored) begin
        $error("register %0d expected %0d got %0d", idx, stored, readback);
        err_cnt++;
      end
    end
  endtask

  // Random gestures under the current settings: clean taps, long holds that can
  // reach setup mode, and bursts of contact bounce.
  task automatic play_gestures();
    int unsigned sent;
    int unsigned pick;
    int unsigned gap_hi;
    int unsigned a;
    int unsigned b;
    sent = 0;
    gap_hi = ((shadow_cfg.debounce_ms > 40) ? 40 : shadow_cfg.debounce_ms) + 10;
    while (sent < SEG_TICKS) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        a = $urandom_range(1, gap_hi);
        b = $urandom_range(1, gap_hi);
        send_run(1'b0, a);
        send_run(1'b1, b);
        sent += a + b;
      end else if (pick < 80) begin
        if (shadow_cfg.long_press_ms > 100) a = $urandom_range(20, 150);
        else a = shadow_cfg.long_press_ms + $urandom_range(1, 60);
        b = $urandom_range(1, gap_hi);
        send_run(1'b0, a);
        send_run(1'b1, b);
        sent += a + b;
      end else begin
        a = $urandom_range(1, 10);
        for (int unsigned i = 0; i < a; i++) send_tick(1'($urandom_range(1)), 1'b0, '0);
        sent += a;
      end
    end
  endtask

  initial begin
    logic [15:0] d_val;
    logic [15:0] a_val;
    logic [15:0] l_val;
    logic [15:0] f_val;
    logic [15:0] s_val;

    // Directed plan. It starts from the reset settings, then walks zero debounce and
    // zero animation period, the setup sweep turning at both ends, zero step sizes,
    // steps of 255 with a long-press time of zero, writes to unused addresses, and
    // finally the slowest settings with a short hold that stays far below the
    // long-press time, so setup mode is not entered.
    plan = '{
      tick_row(1'b1, 1, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0}),
      tick_row(1'b0, 1, 1'b1, '{8'd0, 1'b1, 1'b0, 1'b1}),
      tick_row(1'b0, 70),
      tick_row(1'b1, 70),
      write_row(REG_DEBOUNCE, 32'd0),
      write_row(REG_ANIM_PER, 32'd0),
      write_row(REG_LONG_PRESS, 32'd3),
      write_row(REG_SETUP_STEP, 32'd20),
      tick_row(1'b0, 30),
      tick_row(1'b1, 6),
      write_row(REG_FADE_STEP, 32'd0),
      write_row(REG_SETUP_STEP, 32'd0),
      tick_row(1'b0, 8),
      tick_row(1'b1, 3),
      write_row(REG_FADE_STEP, 32'd255),
      write_row(REG_SETUP_STEP, 32'd255),
      write_row(REG_LONG_PRESS, 32'd0),
      tick_row(1'b0, 4),
      tick_row(1'b1, 3),
      tick_row(1'b0, 2),
      tick_row(1'b1, 2),
      write_row(REG_SPARE_LO, '1),
      write_row(REG_SPARE_HI, '1),
      write_row(REG_DEBOUNCE, 32'd1023),
      write_row(REG_ANIM_PER, 32'd1023),
      write_row(REG_LONG_PRESS, 32'd65535),
      write_row(REG_FADE_STEP, 32'd1),
      tick_row(1'b0, 40),
      tick_row(1'b1, 20)
    };

    snd_idle_pct = 23;
    rcv_idle_pct = 85;
    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NROWS; r++) begin
      if (plan[r].op == ROW_WRITE) begin
        settle();
        reg_write(plan[r].idx, plan[r].val);
      end else begin
        send_run(plan[r].btn, plan[r].reps, plan[r].typed, plan[r].want);
      end
    end

    // Random part. Idling goes from a slow receiver, to a slow sender, to none at all; the
    // settings change per segment, all forced to zero once and all but debounce to the top.
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg < 4) begin
        snd_idle_pct = 23;
        rcv_idle_pct = 85;
      end else if (seg < 7) begin
        snd_idle_pct = 85;
        rcv_idle_pct = 23;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      d_val = pick_field(1023, 12);
      a_val = pick_field(1023, 6);
      l_val = pick_field(65535, 40);
      f_val = pick_field(255, 40);
      s_val = pick_field(255, 64);
      if (seg == 2) begin
        d_val = '0;
        a_val = '0;
        l_val = '0;
        f_val = '0;
        s_val = '0;
      end else if (seg == 5) begin
        f_val = 16'd255;
        s_val = 16'd255;
      end else if (seg == 8) begin
        a_val = 16'd1023;
        l_val = 16'd65535;
      end
      settle();
      reg_write(REG_DEBOUNCE, 32'(d_val));
      reg_write(REG_ANIM_PER, 32'(a_val));
      reg_write(REG_LONG_PRESS, 32'(l_val));
      reg_write(REG_FADE_STEP, 32'(f_val));
      reg_write(REG_SETUP_STEP, 32'(s_val));
      play_gestures();
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/pbfd_pkg.sv
sv/pbfd_engine.sv
sv/push_button_fade_dimmer_core.sv
dv/push_button_fade_dimmer_core_tb.sv
